[sv/fat_cluster_chain_allocator_assert.svh]
// assertion macros for the cluster chain allocator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FCA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fca checker: same-cycle property failed");

// next-cycle implication
`define FCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fca checker: next-cycle property failed");

`endif

[sv/fca_pkg.sv]
// shared types, constants and helpers for the cluster chain allocator
// no dependencies
`default_nettype none

package fca_pkg;

  // table geometry
  localparam int ENTRIES       = 512;
  localparam int CLUSTER_BYTES = 2048;
  localparam int IDX_W         = $clog2(ENTRIES);
  localparam int CNT_W         = $clog2(ENTRIES + 1);
  localparam int CB_SHIFT      = $clog2(CLUSTER_BYTES);

  // word field widths
  localparam int KIND_W    = 2;
  localparam int CLUSTER_W = 9;
  localparam int SIZE_W    = 21;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 10;
  localparam int NEED_W    = SIZE_W - CB_SHIFT + 1;

  // link encodings
  localparam logic [VALUE_W-1:0] LINK_EMPTY = 32'h0000_0000;
  localparam logic [VALUE_W-1:0] LINK_EOC   = 32'h0FFF_FFFF;
  localparam logic [VALUE_W-1:0] LINK_MEDIA = 32'h0FFF_FFF8;
  localparam logic [VALUE_W-1:0] LINK_MASK  = 32'h0FFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_PARTIAL = 2'd2,
    STAT_BADLINK = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_START,
    S_ALLOC_CHK,
    S_ALLOC_END,
    S_FREE_START,
    S_FREE_CHK,
    S_READ_RD,
    S_READ_CAP,
    S_WRITE,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_ALLOC_START,
    CMD_ALLOC_CHK,
    CMD_ALLOC_END,
    CMD_FREE_START,
    CMD_FREE_CHK,
    CMD_READ_RD,
    CMD_READ_CAP,
    CMD_WRITE,
    CMD_POST
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic alloc_stop;
    logic free_start_ok;
    logic free_stop;
    logic out_free;
  } stat_t;

  // contents of an entry right after reset
  function automatic logic [VALUE_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    logic [VALUE_W-1:0] v;
    if (idx == IDX_W'(0)) begin
      v = LINK_MEDIA;
    end else if (idx < IDX_W'(3)) begin
      v = LINK_EOC;
    end else begin
      v = LINK_EMPTY;
    end
    return v;
  endfunction

  function automatic logic is_end_mark(input logic [VALUE_W-1:0] v);
    return (v & LINK_MASK) >= LINK_MEDIA;
  endfunction

endpackage

`default_nettype wire

[sv/fca_ifs.sv]
// valid/ready channel interfaces for the command and result words
// depends on fca_pkg
`default_nettype none

interface fca_in_if import fca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [CLUSTER_W-1:0] cluster;
  logic [SIZE_W-1:0]    byte_size;
  logic [VALUE_W-1:0]   entry_value;

  modport source (output valid, kind, cluster, byte_size, entry_value, input ready);
  modport sink   (input valid, kind, cluster, byte_size, entry_value, output ready);
endinterface

interface fca_out_if import fca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CLUSTER_W-1:0] chain_head;
  logic [COUNT_W-1:0]   chain_len;
  logic [VALUE_W-1:0]   read_value;

  modport source (output valid, status, chain_head, chain_len, read_value,
                  input ready);
  modport sink   (input valid, status, chain_head, chain_len, read_value,
                  output ready);
endinterface

`default_nettype wire

[sv/fat_cluster_chain_allocator.sv]
// Cluster chain allocator: a 512-entry link table with allocate, free, read and write.
// Command words arrive on in_ch (valid/ready), one result word per command leaves
// on out_ch (valid/ready), held in an output register until taken.
// One command is worked on at a time; in_ch.ready is high only while idle.
// Allocate scans from entry 0 up to the last free entry taken (or the table end),
// one table read per cycle; free follows the chain one link per cycle.
// A new command is taken the cycle after its result is posted, even while that
// result still waits on out_ch.ready; if the previous result was not taken by
// then, the block holds the finished result internally until the register frees.
// After reset the table is rewritten one entry a cycle to its
// reset contents; in_ch.ready stays low for that pass.
// Depends on fca_pkg, fca_ifs, fca_ctrl, fca_dpath.
`default_nettype none

module fat_cluster_chain_allocator import fca_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  fca_in_if.sink   in_ch,
  fca_out_if.source out_ch
);

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;

  fca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  fca_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_kind        (in_ch.kind),
    .in_cluster     (in_ch.cluster),
    .in_byte_size   (in_ch.byte_size),
    .in_entry_value (in_ch.entry_value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_chain_head (out_ch.chain_head),
    .out_chain_len  (out_ch.chain_len),
    .out_read_value (out_ch.read_value)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[sv/fca_table.sv]
// link table memory: one write and one read port, registered read data
// write-first when both ports hit the same entry; depends on fca_pkg
`default_nettype none

module fca_table import fca_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [IDX_W-1:0]   raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [ENTRIES];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/fca_dpath.sv]
// datapath: command registers, scan and walk counters, table ports and result word
// depends on fca_pkg and fca_table
`default_nettype none

module fca_dpath import fca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl,
  output stat_t                stat,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [CLUSTER_W-1:0] in_cluster,
  input  logic [SIZE_W-1:0]    in_byte_size,
  input  logic [VALUE_W-1:0]   in_entry_value,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [CLUSTER_W-1:0] out_chain_head,
  output logic [COUNT_W-1:0]   out_chain_len,
  output logic [VALUE_W-1:0]   out_read_value
);

  kind_t                kind_r, kind_nxt;
  logic [CLUSTER_W-1:0] cluster_r, cluster_nxt;
  logic [NEED_W-1:0]    need_r, need_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  logic [IDX_W-1:0]     chk_r, chk_nxt;
  logic [IDX_W-1:0]     first_r, first_nxt;
  logic [IDX_W-1:0]     prev_r, prev_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     got_r, got_nxt;
  logic [CNT_W-1:0]     steps_r, steps_nxt;
  status_t              free_st_r, free_st_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [CLUSTER_W-1:0] out_start_r, out_start_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;

  logic              in_range;
  logic              hit;
  logic [CNT_W-1:0]  got_inc;
  logic [NEED_W-1:0] need_raw;

  fca_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_range = (32'(cluster_r) < 32'(ENTRIES));
  assign hit      = (rdata == LINK_EMPTY);
  assign got_inc  = got_r + CNT_W'(1);
  // clusters needed: round up; a zero result is raised to one on load
  assign need_raw = NEED_W'(in_byte_size >> CB_SHIFT)
                  + NEED_W'(|(in_byte_size & SIZE_W'(CLUSTER_BYTES - 1)));

  always_comb begin
    stat.clear_last    = (clr_r == IDX_W'(ENTRIES - 1));
    stat.alloc_stop    = (hit && (NEED_W'(got_inc) == need_r))
                       || (chk_r == IDX_W'(ENTRIES - 1));
    stat.free_start_ok = in_range;
    stat.free_stop     = hit || is_end_mark(rdata)
                       || ((steps_r + CNT_W'(1)) == CNT_W'(ENTRIES))
                       || (rdata >= 32'(ENTRIES));
    stat.out_free      = !out_valid_r || out_ready;
  end

  always_comb begin
    kind_nxt       = kind_r;
    cluster_nxt    = cluster_r;
    need_nxt       = need_r;
    value_nxt      = value_r;
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    chk_nxt        = chk_r;
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    got_nxt        = got_r;
    steps_nxt      = steps_r;
    free_st_nxt    = free_st_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_count_nxt  = out_count_r;
    out_value_nxt  = out_value_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = LINK_EMPTY;
    raddr          = '0;

    unique case (ctl.cmd)
      CMD_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = link_reset(clr_r);
        clr_nxt = clr_r + IDX_W'(1);
      end
      CMD_LOAD: begin
        kind_nxt    = kind_t'(in_kind);
        cluster_nxt = in_cluster;
        need_nxt    = (need_raw == '0) ? NEED_W'(1) : need_raw;
        value_nxt   = in_entry_value;
      end
      CMD_ALLOC_START: begin
        raddr     = '0;
        scan_nxt  = IDX_W'(1);
        chk_nxt   = '0;
        got_nxt   = '0;
        first_nxt = '0;
        prev_nxt  = '0;
      end
      CMD_ALLOC_CHK: begin
        // reads run one entry ahead of the check
        raddr    = scan_r;
        scan_nxt = scan_r + IDX_W'(1);
        chk_nxt  = scan_r;
        if (hit) begin
          got_nxt  = got_inc;
          prev_nxt = chk_r;
          if (got_r == '0) begin
            first_nxt = chk_r;
          end else begin
            we    = 1'b1;
            waddr = prev_r;
            wdata = 32'(chk_r);
          end
        end
      end
      CMD_ALLOC_END: begin
        if (got_r != '0) begin
          we    = 1'b1;
          waddr = prev_r;
          wdata = LINK_EOC;
        end
      end
      CMD_FREE_START: begin
        raddr       = IDX_W'(cluster_r);
        cur_nxt     = IDX_W'(cluster_r);
        steps_nxt   = '0;
        got_nxt     = '0;
        free_st_nxt = STAT_BADLINK;
      end
      CMD_FREE_CHK: begin
        if (!hit) begin
          we      = 1'b1;
          waddr   = cur_r;
          wdata   = LINK_EMPTY;
          got_nxt = got_inc;
          if (is_end_mark(rdata)) begin
            free_st_nxt = STAT_OK;
          end else begin
            // follow the link straight from the read register
            raddr     = rdata[IDX_W-1:0];
            cur_nxt   = rdata[IDX_W-1:0];
            steps_nxt = steps_r + CNT_W'(1);
          end
        end
      end
      CMD_READ_RD: begin
        raddr = IDX_W'(cluster_r);
      end
      CMD_READ_CAP: begin
        value_nxt = in_range ? rdata : LINK_EMPTY;
      end
      CMD_WRITE: begin
        if (in_range) begin
          we    = 1'b1;
          waddr = IDX_W'(cluster_r);
          wdata = value_r;
        end
      end
      CMD_POST: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_start_nxt  = '0;
        out_count_nxt  = '0;
        out_value_nxt  = '0;
        case (kind_r)
          KIND_ALLOC: begin
            if (got_r == '0) begin
              out_status_nxt = STAT_FULL;
            end else begin
              out_status_nxt = (NEED_W'(got_r) < need_r) ? STAT_PARTIAL : STAT_OK;
              out_start_nxt  = CLUSTER_W'(first_r);
              out_count_nxt  = COUNT_W'(got_r);
            end
          end
          KIND_FREE: begin
            out_status_nxt = free_st_r;
            out_count_nxt  = COUNT_W'(got_r);
          end
          KIND_READ: begin
            out_value_nxt = value_r;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    cluster_r    <= cluster_nxt;
    need_r       <= need_nxt;
    value_r      <= value_nxt;
    scan_r       <= scan_nxt;
    chk_r        <= chk_nxt;
    first_r      <= first_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    got_r        <= got_nxt;
    steps_r      <= steps_nxt;
    free_st_r    <= free_st_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_count_r  <= out_count_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_chain_head = out_start_r;
  assign out_chain_len  = out_count_r;
  assign out_read_value = out_value_r;

endmodule

`default_nettype wire

[sv/fca_ctrl.sv]
// controller: sequences table clear, allocate scan, free walk, read and write
// depends on fca_pkg
`default_nettype none

module fca_ctrl import fca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  input  stat_t             stat,
  output logic              in_ready,
  output ctl_t              ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.cmd   = CMD_NONE;
    in_ready  = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd = CMD_LOAD;
          unique case (kind_t'(in_kind))
            KIND_ALLOC: state_nxt = S_ALLOC_START;
            KIND_FREE:  state_nxt = S_FREE_START;
            KIND_READ:  state_nxt = S_READ_RD;
            KIND_WRITE: state_nxt = S_WRITE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC_START: begin
        ctl.cmd   = CMD_ALLOC_START;
        state_nxt = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        ctl.cmd = CMD_ALLOC_CHK;
        if (stat.alloc_stop) begin
          state_nxt = S_ALLOC_END;
        end
      end
      S_ALLOC_END: begin
        ctl.cmd   = CMD_ALLOC_END;
        state_nxt = S_DONE;
      end
      S_FREE_START: begin
        ctl.cmd   = CMD_FREE_START;
        state_nxt = stat.free_start_ok ? S_FREE_CHK : S_DONE;
      end
      S_FREE_CHK: begin
        ctl.cmd = CMD_FREE_CHK;
        if (stat.free_stop) begin
          state_nxt = S_DONE;
        end
      end
      S_READ_RD: begin
        ctl.cmd   = CMD_READ_RD;
        state_nxt = S_READ_CAP;
      end
      S_READ_CAP: begin
        ctl.cmd   = CMD_READ_CAP;
        state_nxt = S_DONE;
      end
      S_WRITE: begin
        ctl.cmd   = CMD_WRITE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to free up
        if (stat.out_free) begin
          ctl.cmd   = CMD_POST;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/fca_checker.sv]
// port-level checker for the cluster chain allocator, bound to the top level
// depends on fca_pkg and fat_cluster_chain_allocator_assert.svh
`default_nettype none

`include "fat_cluster_chain_allocator_assert.svh"

module fca_checker import fca_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STATUS_W-1:0]  out_status,
  input logic [CLUSTER_W-1:0] out_chain_head,
  input logic [COUNT_W-1:0]   out_chain_len,
  input logic [VALUE_W-1:0]   out_read_value
);

  logic [STATUS_W+CLUSTER_W+COUNT_W+VALUE_W-1:0] out_word;
  logic                                          full_seen;
  logic                                          no_chain;

  assign out_word  = {out_status, out_chain_head, out_chain_len, out_read_value};
  assign full_seen = out_valid && (out_status == STAT_FULL);
  assign no_chain  = (out_chain_head == '0) && (out_chain_len == '0);

  `FCA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FCA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))
  `FCA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `FCA_ASSERT_IMPL(a_full_empty, full_seen, no_chain)
  `FCA_ASSERT_IMPL(a_count_range, out_valid, out_chain_len <= COUNT_W'(ENTRIES))

endmodule

bind fat_cluster_chain_allocator fca_checker u_fca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_chain_head (out_ch.chain_head),
  .out_chain_len  (out_ch.chain_len),
  .out_read_value (out_ch.read_value)
);

`default_nettype wire

[sim/tb_fat_cluster_chain_allocator.sv]
// self-checking testbench for the cluster chain allocator: random and directed commands
// checked word by word against an in-bench model of the link table
// depends on fca_pkg, fca_ifs and the fat_cluster_chain_allocator rtl
module tb_fat_cluster_chain_allocator;
  import fca_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic [CLUSTER_W-1:0] cluster;
    logic [SIZE_W-1:0]    byte_size;
    logic [VALUE_W-1:0]   entry_value;
  } fat_cmd_t;

  typedef struct packed {
    status_t              status;
    logic [CLUSTER_W-1:0] chain_head;
    logic [COUNT_W-1:0]   chain_len;
    logic [VALUE_W-1:0]   read_value;
  } fat_reply_t;

  // two copies of the table: one follows accepted words, one follows stimulus generation
  localparam int CHECK_COPY = 0;
  localparam int GEN_COPY   = 1;
  localparam int HOLD_CYCLES = 3000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fca_in_if  in_ch ();
  fca_out_if out_ch ();

  fat_cluster_chain_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic     drv_valid = 1'b0;
  fat_cmd_t drv_cmd   = '0;
  logic     rcv_ready = 1'b0;

  assign in_ch.valid       = drv_valid;
  assign in_ch.kind        = drv_cmd.kind;
  assign in_ch.cluster     = drv_cmd.cluster;
  assign in_ch.byte_size   = drv_cmd.byte_size;
  assign in_ch.entry_value = drv_cmd.entry_value;
  assign out_ch.ready      = rcv_ready;

  logic [VALUE_W-1:0] chain_table [2][ENTRIES];
  fat_cmd_t           cmd_queue[$];
  fat_reply_t         expected_replies[$];
  int unsigned        chain_heads[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned fail_cnt     = 0;
  int unsigned kind_cnt [4];
  int unsigned stat_cnt [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one command to a table copy and returns the result word it gives
  function automatic fat_reply_t run_table_cmd(input int copy, input fat_cmd_t c);
    fat_reply_t         r;
    int unsigned        need;
    int unsigned        got;
    int unsigned        first;
    int unsigned        prev;
    int unsigned        cur;
    int unsigned        i;
    logic [VALUE_W-1:0] v;
    bit                 found;
    r = '0;
    r.status = STAT_OK;
    case (c.kind)
      KIND_ALLOC: begin
        need = (int'(c.byte_size) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
        if (need == 0) need = 1;
        found = 1'b0;
        first = 0;
        for (i = 0; i < ENTRIES; i++) begin
          if (chain_table[copy][i] == LINK_EMPTY) begin
            first = i;
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          r.status = STAT_FULL;
        end else begin
          chain_table[copy][first] = LINK_EOC;
          got  = 1;
          prev = first;
          for (i = first + 1; i < ENTRIES && got < need; i++) begin
            if (chain_table[copy][i] == LINK_EMPTY) begin
              chain_table[copy][prev] = i;
              chain_table[copy][i]    = LINK_EOC;
              prev = i;
              got++;
            end
          end
          r.status     = (got < need) ? STAT_PARTIAL : STAT_OK;
          r.chain_head = first[CLUSTER_W-1:0];
          r.chain_len  = got[COUNT_W-1:0];
        end
      end
      KIND_FREE: begin
        r.status = STAT_BADLINK;
        cur = 32'(c.cluster);
        got = 0;
        for (i = 0; i < ENTRIES; i++) begin
          if (cur >= ENTRIES) break;
          v = chain_table[copy][cur];
          if (v == LINK_EMPTY) break;
          chain_table[copy][cur] = LINK_EMPTY;
          got++;
          // end mark is judged on the low 28 bits only
          if ((v & LINK_MASK) >= LINK_MEDIA) begin
            r.status = STAT_OK;
            break;
          end
          cur = v;
        end
        r.chain_len = got[COUNT_W-1:0];
      end
      KIND_READ: begin
        r.read_value = chain_table[copy][c.cluster];
      end
      default: begin
        chain_table[copy][c.cluster] = c.entry_value;
      end
    endcase
    return r;
  endfunction

  task automatic queue_cmd(input kind_t k, input int unsigned idx, input int unsigned size,
                           input logic [VALUE_W-1:0] val, output fat_reply_t r);
    fat_cmd_t c;
    c.kind        = k;
    c.cluster     = idx[CLUSTER_W-1:0];
    c.byte_size   = size[SIZE_W-1:0];
    c.entry_value = val;
    cmd_queue.push_back(c);
    r = run_table_cmd(GEN_COPY, c);
    if (k == KIND_ALLOC && r.status != STAT_FULL) chain_heads.push_back(32'(r.chain_head));
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_ch.ready) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_valid <= 1'b1;
        drv_cmd   <= cmd_queue.pop_front();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // accepted commands feed the model
  always @(posedge clk) begin
    if (rst_n && drv_valid && in_ch.ready) begin
      expected_replies.push_back(run_table_cmd(CHECK_COPY, drv_cmd));
      kind_cnt[drv_cmd.kind]++;
      accepted_cnt++;
    end
  end

  // result side ready, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rcv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    fat_reply_t exp_r;
    if (rst_n && out_ch.valid && rcv_ready) begin
      if (expected_replies.size() == 0) begin
        $error("result word with nothing expected: status %0d count %0d",
               out_ch.status, out_ch.chain_len);
        fail_cnt++;
      end else begin
        exp_r = expected_replies.pop_front();
        checked_cnt++;
        stat_cnt[out_ch.status]++;
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          fail_cnt++;
        end
        if (out_ch.chain_head !== exp_r.chain_head) begin
          $error("chain_head: expected %0d, got %0d", exp_r.chain_head,
                 out_ch.chain_head);
          fail_cnt++;
        end
        if (out_ch.chain_len !== exp_r.chain_len) begin
          $error("chain_len: expected %0d, got %0d", exp_r.chain_len,
                 out_ch.chain_len);
          fail_cnt++;
        end
        if (out_ch.read_value !== exp_r.read_value) begin
          $error("read_value: expected %0h, got %0h", exp_r.read_value, out_ch.read_value);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    fat_reply_t  r;
    int unsigned n;
    int unsigned pick;
    int unsigned sel;
    int unsigned idx;
    int unsigned size;
    int unsigned total;
    int unsigned ph;
    logic [VALUE_W-1:0] val;

    for (n = 0; n < ENTRIES; n++) begin
      val = (n == 0) ? LINK_MEDIA : (n < 3) ? LINK_EOC : LINK_EMPTY;
      chain_table[CHECK_COPY][n] = val;
      chain_table[GEN_COPY][n]   = val;
    end
    for (n = 0; n < 4; n++) begin
      kind_cnt[n] = 0;
      stat_cnt[n] = 0;
    end

    // directed part
    queue_cmd(KIND_READ, 0, 0, '0, r);
    queue_cmd(KIND_READ, 1, 0, '1, r);
    queue_cmd(KIND_READ, ENTRIES - 1, '1, '0, r);
    queue_cmd(KIND_ALLOC, 0, 0, '0, r);                    // zero size still takes one
    queue_cmd(KIND_ALLOC, 0, 1, '0, r);
    queue_cmd(KIND_ALLOC, 0, CLUSTER_BYTES, '0, r);
    queue_cmd(KIND_ALLOC, ENTRIES - 1, CLUSTER_BYTES + 1, '1, r);
    idx = 32'(r.chain_head);
    queue_cmd(KIND_READ, idx, 0, '0, r);
    queue_cmd(KIND_FREE, idx, 0, '0, r);
    queue_cmd(KIND_FREE, idx, 0, '0, r);                   // start entry already empty
    queue_cmd(KIND_WRITE, 10, 0, 32'h1000_0005, r);        // link past the table
    queue_cmd(KIND_FREE, 10, 0, '0, r);
    queue_cmd(KIND_WRITE, 20, 0, 32'd21, r);               // two-entry loop
    queue_cmd(KIND_WRITE, 21, 0, 32'd20, r);
    queue_cmd(KIND_FREE, 20, 0, '0, r);
    queue_cmd(KIND_WRITE, ENTRIES - 1, 0, 32'hFFFF_FFFF, r); // end mark with top bits set
    queue_cmd(KIND_READ, ENTRIES - 1, 0, '0, r);
    queue_cmd(KIND_FREE, ENTRIES - 1, 0, '0, r);
    queue_cmd(KIND_FREE, 1, 0, '0, r);                     // reserved entry
    queue_cmd(KIND_ALLOC, 0, (1 << SIZE_W) - 1, '0, r);    // short table
    idx = 32'(r.chain_head);
    queue_cmd(KIND_ALLOC, 0, 0, '0, r);                    // table full
    queue_cmd(KIND_FREE, idx, 0, '0, r);
    queue_cmd(KIND_ALLOC, 0, ENTRIES * CLUSTER_BYTES, '0, r);
    queue_cmd(KIND_FREE, 32'(r.chain_head), 0, '0, r);
    queue_cmd(KIND_FREE, 0, 0, '0, r);                     // media entry

    // random part: mostly alloc/free of live chains, some reads and stray writes
    for (n = 0; n < 650; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        sel = $urandom_range(99);
        if (sel < 5) begin
          size = $urandom_range((1 << SIZE_W) - 1);
        end else if (sel < 15) begin
          size = $urandom_range(0, 8) * CLUSTER_BYTES;
        end else begin
          size = $urandom_range(0, 6 * CLUSTER_BYTES);
        end
        queue_cmd(KIND_ALLOC, $urandom_range(ENTRIES - 1), size, $urandom, r);
      end else if (pick < 75) begin
        if (chain_heads.size() != 0 && $urandom_range(9) != 0) begin
          sel = $urandom_range(chain_heads.size() - 1);
          idx = chain_heads[sel];
          chain_heads.delete(sel);
        end else begin
          idx = $urandom_range(ENTRIES - 1);
        end
        queue_cmd(KIND_FREE, idx, $urandom_range((1 << SIZE_W) - 1), $urandom, r);
      end else if (pick < 88) begin
        if (chain_heads.size() != 0 && $urandom_range(1) == 0) begin
          idx = chain_heads[$urandom_range(chain_heads.size() - 1)];
        end else begin
          idx = $urandom_range(ENTRIES - 1);
        end
        queue_cmd(KIND_READ, idx, $urandom_range((1 << SIZE_W) - 1), $urandom, r);
      end else begin
        sel = $urandom_range(4);
        case (sel)
          0, 1: val = $urandom;
          2:    val = LINK_EMPTY;
          3:    val = LINK_EOC;
          default: val = $urandom_range(ENTRIES - 1);
        endcase
        queue_cmd(KIND_WRITE, $urandom_range(ENTRIES - 1), $urandom_range((1 << SIZE_W) - 1),
                  val, r);
      end
    end
    total = cmd_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 53;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 53;
        end
        default: begin
          send_idle_pct  <= 18;
          recv_stall_pct <= 18;
        end
      endcase
      while (accepted_cnt < (ph + 1) * total / 4) begin
        @(posedge clk);
        // long result stall while commands keep coming
        if (ph == 0 && accepted_cnt >= 40) hold_req <= 1'b1;
      end
    end

    while (cmd_queue.size() != 0 || drv_valid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("summary: %0d words checked: %0d allocate, %0d free, %0d read, %0d write",
             checked_cnt, kind_cnt[KIND_ALLOC], kind_cnt[KIND_FREE], kind_cnt[KIND_READ],
             kind_cnt[KIND_WRITE]);
    $display("summary: status ok %0d, full %0d, partial %0d, bad link %0d",
             stat_cnt[STAT_OK], stat_cnt[STAT_FULL], stat_cnt[STAT_PARTIAL],
             stat_cnt[STAT_BADLINK]);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[fat_cluster_chain_allocator.f]
+incdir+sv
sv/fca_pkg.sv
sv/fca_ifs.sv
sv/fca_table.sv
sv/fca_dpath.sv
sv/fca_ctrl.sv
sv/fat_cluster_chain_allocator.sv
sv/fca_checker.sv
sim/tb_fat_cluster_chain_allocator.sv
